/* hw/rtl/gcd_lcm_unit_core_assert.svh */
// assertion macros for the gcd/lcm unit
`ifndef GCD_LCM_UNIT_CORE_ASSERT_SVH
`define GCD_LCM_UNIT_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define GLU_ASSERT_IMPL(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define GLU_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/glu_pkg.sv */
// shared constants and types for the gcd/lcm unit
`default_nettype none

package glu_pkg;

	localparam int DATA_WIDTH_DEF  = 64;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic FUNC_GCD = 1'b0;
	localparam logic FUNC_LCM = 1'b1;

	// how the back end has to treat an item
	typedef enum logic [1:0] {
		KIND_EUCLID = 2'd0,
		KIND_PASS_A = 2'd1,
		KIND_PASS_B = 2'd2,
		KIND_ZERO   = 2'd3
	} kind_t;

	localparam int KIND_W = $bits(kind_t);

endpackage

`default_nettype wire

/* hw/rtl/glu_front.sv */
// input stage: takes transactions and classifies them for the back end
`default_nettype none

module glu_front #(
	parameter int DATA_WIDTH = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output      logic                                in_stall,
	input  wire logic                                func,
	input  wire logic [DATA_WIDTH-1:0]               operand_a,
	input  wire logic [DATA_WIDTH-1:0]               operand_b,
	input  wire logic                                q_full,
	output      logic                                push,
	output      logic [glu_pkg::KIND_W+2*DATA_WIDTH:0] push_data
);
	import glu_pkg::*;

	logic                  valid_s1;
	kind_t                 kind_s1;
	logic                  func_s1;
	logic [DATA_WIDTH-1:0] a_s1;
	logic [DATA_WIDTH-1:0] b_s1;
	logic                  accept;
	kind_t                 kind_in;
	logic                  a_zero;
	logic                  b_zero;

	assign a_zero = (operand_a == '0);
	assign b_zero = (operand_b == '0);

	always_comb begin
		priority if (func == FUNC_GCD && b_zero) begin
			kind_in = KIND_PASS_A;
		end else if (func == FUNC_GCD && a_zero) begin
			kind_in = KIND_PASS_B;
		end else if (a_zero || b_zero) begin
			kind_in = KIND_ZERO;
		end else begin
			kind_in = KIND_EUCLID;
		end
	end

	assign in_stall  = valid_s1 && q_full;
	assign accept    = in_valid && !in_stall;
	assign push      = valid_s1 && !q_full;
	assign push_data = {kind_s1, func_s1, a_s1, b_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind_in;
			func_s1 <= func;
			a_s1    <= operand_a;
			b_s1    <= operand_b;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/glu_queue.sv */
// short fifo between the front and back ends
`default_nettype none

module glu_queue #(
	parameter int ENTRY_W = 8,
	parameter int DEPTH   = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire logic [ENTRY_W-1:0] push_data,
	input  wire logic               pop,
	output      logic [ENTRY_W-1:0] pop_data,
	output      logic               full,
	output      logic               empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [ENTRY_W-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = slot_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		next_ptr = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/glu_div.sv */
// restoring divider, one quotient bit per cycle
`default_nettype none

module glu_div #(
	parameter int DATA_WIDTH = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [DATA_WIDTH-1:0] dividend,
	input  wire logic [DATA_WIDTH-1:0] divisor,
	output      logic                  done,
	output      logic [DATA_WIDTH-1:0] quotient,
	output      logic [DATA_WIDTH-1:0] remainder
);
	localparam int CNT_W = $clog2(DATA_WIDTH);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH-1:0] quo_q;
	logic [DATA_WIDTH-1:0] dsr_q;
	logic [DATA_WIDTH:0]   shifted;
	logic [DATA_WIDTH:0]   diff;
	logic                  ge;

	assign shifted = {rem_q, quo_q[DATA_WIDTH-1]};
	assign diff    = shifted - {1'b0, dsr_q};
	assign ge      = !diff[DATA_WIDTH];

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DATA_WIDTH - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
			quo_q <= {quo_q[DATA_WIDTH-2:0], ge};
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/glu_back.sv */
// execution sequencer: euclid loop, quotient, shift-add multiply, result register
`default_nettype none

module glu_back #(
	parameter int DATA_WIDTH = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                q_empty,
	input  wire logic [glu_pkg::KIND_W+2*DATA_WIDTH:0] q_data,
	output      logic                                pop,
	output      logic                                out_valid,
	input  wire logic                                out_stall,
	output      logic [DATA_WIDTH-1:0]               result
);
	import glu_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EUCLID,
		ST_QUOT,
		ST_MUL,
		ST_OUT
	} state_t;

	state_t                state_q;
	logic                  start_q;
	logic                  func_q;
	logic [DATA_WIDTH-1:0] a_q;
	logic [DATA_WIDTH-1:0] b_q;
	logic [DATA_WIDTH-1:0] x_q;
	logic [DATA_WIDTH-1:0] y_q;
	logic [DATA_WIDTH-1:0] mc_q;
	logic [DATA_WIDTH-1:0] mp_q;
	logic [DATA_WIDTH-1:0] acc_q;
	logic                  out_valid_q;
	logic [DATA_WIDTH-1:0] result_q;

	kind_t                 q_kind;
	logic                  q_func;
	logic [DATA_WIDTH-1:0] q_a;
	logic [DATA_WIDTH-1:0] q_b;
	logic                  div_done;
	logic [DATA_WIDTH-1:0] div_quo;
	logic [DATA_WIDTH-1:0] div_rem;
	logic                  load_out;

	assign q_kind = kind_t'(q_data[KIND_W+2*DATA_WIDTH:2*DATA_WIDTH+1]);
	assign q_func = q_data[2*DATA_WIDTH];
	assign q_a    = q_data[2*DATA_WIDTH-1:DATA_WIDTH];
	assign q_b    = q_data[DATA_WIDTH-1:0];

	assign pop       = (state_q == ST_IDLE) && !q_empty;
	assign out_valid = out_valid_q;
	assign result    = result_q;

	// result register is free or being taken this cycle
	assign load_out = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	glu_div #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (x_q),
		.divisor  (y_q),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
			func_q      <= 1'b0;
			a_q         <= '0;
			b_q         <= '0;
			x_q         <= '0;
			y_q         <= '0;
			mc_q        <= '0;
			mp_q        <= '0;
			acc_q       <= '0;
			result_q    <= '0;
		end else begin
			start_q <= 1'b0;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						func_q <= q_func;
						a_q    <= q_a;
						b_q    <= q_b;
						unique case (q_kind)
							KIND_PASS_A: begin
								acc_q   <= q_a;
								state_q <= ST_OUT;
							end
							KIND_PASS_B: begin
								acc_q   <= q_b;
								state_q <= ST_OUT;
							end
							KIND_ZERO: begin
								acc_q   <= '0;
								state_q <= ST_OUT;
							end
							default: begin
								x_q     <= q_a;
								y_q     <= q_b;
								start_q <= 1'b1;
								state_q <= ST_EUCLID;
							end
						endcase
					end
				end
				ST_EUCLID: begin
					if (div_done) begin
						if (div_rem == '0) begin
							// y_q is the gcd here
							if (func_q == FUNC_GCD) begin
								acc_q   <= y_q;
								state_q <= ST_OUT;
							end else begin
								x_q     <= a_q;
								start_q <= 1'b1;
								state_q <= ST_QUOT;
							end
						end else begin
							x_q     <= y_q;
							y_q     <= div_rem;
							start_q <= 1'b1;
						end
					end
				end
				ST_QUOT: begin
					if (div_done) begin
						mc_q    <= div_quo;
						mp_q    <= b_q;
						acc_q   <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					// product wraps at the data width
					if (mp_q == '0) begin
						state_q <= ST_OUT;
					end else begin
						if (mp_q[0]) begin
							acc_q <= acc_q + mc_q;
						end
						mc_q <= {mc_q[DATA_WIDTH-2:0], 1'b0};
						mp_q <= {1'b0, mp_q[DATA_WIDTH-1:1]};
					end
				end
				ST_OUT: begin
					if (load_out) begin
						result_q <= acc_q;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/gcd_lcm_unit_core.sv */
// top level of the gcd/lcm unit
//
// usage: one transaction on the input channel (func, operand_a, operand_b) gives one
// transaction on the output channel (result), in input order. func selects the
// greatest common divisor or the least common multiple; an lcm that does not fit
// wraps at DATA_WIDTH bits. both channels use valid/stall.
// the front stage registers and classifies each transaction and hands it to a
// queue of QUEUE_DEPTH entries; the back end works on one item at a time.
// an item with a zero operand goes straight to the result register; otherwise the
// back end runs remainder steps on the shared one-bit-per-cycle divider until the
// remainder is zero; an lcm adds one more division and a shift-add multiply.
// the back end takes a new item from the queue only once it is done with the last.
// a stalled output holds its result while the back end finishes the next item;
// in_stall rises once the front stage and queue are full.
// reset (arst_n low) empties the front stage, queue and sequencer; no state
// survives between items.
`default_nettype none
`include "gcd_lcm_unit_core_assert.svh"

module gcd_lcm_unit_core #(
	parameter int DATA_WIDTH  = glu_pkg::DATA_WIDTH_DEF,
	parameter int QUEUE_DEPTH = glu_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output      logic                  in_stall,
	input  wire logic                  func,
	input  wire logic [DATA_WIDTH-1:0] operand_a,
	input  wire logic [DATA_WIDTH-1:0] operand_b,
	output      logic                  out_valid,
	input  wire logic                  out_stall,
	output      logic [DATA_WIDTH-1:0] result
);
	import glu_pkg::*;

	localparam int ENTRY_W = KIND_W + 2 * DATA_WIDTH + 1;

	logic               push;
	logic               pop;
	logic               q_full;
	logic               q_empty;
	logic [ENTRY_W-1:0] push_data;
	logic [ENTRY_W-1:0] pop_data;

	glu_front #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.operand_a(operand_a),
		.operand_b(operand_b),
		.q_full   (q_full),
		.push     (push),
		.push_data(push_data)
	);

	glu_queue #(
		.ENTRY_W(ENTRY_W),
		.DEPTH  (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.full     (q_full),
		.empty    (q_empty)
	);

	glu_back #(
		.DATA_WIDTH(DATA_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_data   (pop_data),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result   (result)
	);

	`GLU_ASSERT_IMPL(a_no_overflow, clk, arst_n, push, !q_full, "push into a full queue")
	`GLU_ASSERT_IMPL(a_no_underflow, clk, arst_n, pop, !q_empty, "pop from an empty queue")
	`GLU_ASSERT_IMPL(a_stall_cause, clk, arst_n, in_stall, q_full, "input stalled with queue space")
	`GLU_ASSERT_NEXT(a_pop_then_free, clk, arst_n, pop && !push, !q_full, "queue full after a pop")

endmodule

`default_nettype wire
